// ----- design/bmsi_pkg.sv -----
`timescale 1ns / 1ps

package bmsi_pkg;

  // input item kinds
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // address bits 15..12 of a bus write
  localparam logic [3:0] BLK_PRG0      = 4'h8;
  localparam logic [3:0] BLK_PRG1      = 4'h9;
  localparam logic [3:0] BLK_CHR_FIRST = 4'hB;
  localparam logic [3:0] BLK_CHR_LAST  = 4'hE;
  localparam logic [3:0] BLK_IRQ       = 4'hF;

  // address bits 1..0 inside the irq block
  localparam logic [1:0] IRQ_RELOAD  = 2'd0;
  localparam logic [1:0] IRQ_CONTROL = 2'd1;
  localparam logic [1:0] IRQ_ACK     = 2'd2;

  // configuration register indexes
  localparam logic CFG_CHR_IS_RAM  = 1'b0;
  localparam logic CFG_QUAD_SCREEN = 1'b1;

  localparam int NUM_CHR = 8;

  typedef enum logic [1:0] {
    CHANGE_NONE   = 2'd0,
    CHANGE_PRG    = 2'd1,
    CHANGE_CHR    = 2'd2,
    CHANGE_MIRROR = 2'd3
  } change_t;

  typedef logic [NUM_CHR-1:0][7:0] chr_banks_t;

  // state update controls from the decoder, already qualified by accept
  typedef struct packed {
    logic       prg_we;
    logic       prg_slot;
    logic       chr_we;
    logic [2:0] chr_slot;
    logic [7:0] chr_value;
    logic       mirror_we;
    logic       irq_reload_we;
    logic       irq_control_we;
    logic       irq_ack;
    logic       tick;
    logic [7:0] wdata;
  } ctl_t;

endpackage

// ----- design/bmsi_decode.sv -----
`timescale 1ns / 1ps

module bmsi_decode (
  input  logic                accept,
  input  logic                operation,
  input  logic [15:0]         address,
  input  logic [7:0]          data,
  input  logic                rendering_on,
  input  logic                chr_is_ram,
  input  logic                quad_screen,
  input  bmsi_pkg::chr_banks_t chr_banks,
  output bmsi_pkg::ctl_t      ctl,
  output logic [1:0]          change,
  output logic [2:0]          slot,
  output logic [7:0]          bank
);
  import bmsi_pkg::*;

  logic [3:0] block;
  logic [3:0] chr_off;
  logic [2:0] chr_idx;
  logic [7:0] chr_old;
  logic [7:0] chr_new;
  change_t    chg;
  ctl_t       want;

  assign block   = address[15:12];
  assign chr_off = block - BLK_CHR_FIRST;
  assign chr_idx = {chr_off[1:0], address[2]};
  assign chr_old = chr_banks[chr_idx];
  // address bit 1 picks the high nibble
  assign chr_new = address[1] ? {data[3:0], chr_old[3:0]} : {chr_old[7:4], data[3:0]};

  always_comb begin
    want      = '0;
    want.wdata = data;
    want.chr_slot  = chr_idx;
    want.chr_value = chr_new;
    chg  = CHANGE_NONE;
    slot = 3'd0;
    bank = 8'd0;
    if (operation == OP_TICK) begin
      want.tick = rendering_on;
    end else begin
      case (block)
        BLK_PRG0: begin
          want.prg_we   = 1'b1;
          want.prg_slot = 1'b0;
          chg  = CHANGE_PRG;
          bank = {3'd0, data[4:0]};
        end
        BLK_PRG1: begin
          if (address[1]) begin
            want.mirror_we = 1'b1;
            chg = quad_screen ? CHANGE_NONE : CHANGE_MIRROR;
          end else begin
            want.prg_we   = 1'b1;
            want.prg_slot = 1'b1;
            chg  = CHANGE_PRG;
            slot = 3'd1;
            bank = {3'd0, data[4:0]};
          end
        end
        BLK_IRQ: begin
          case (address[1:0])
            IRQ_RELOAD:  want.irq_reload_we  = 1'b1;
            IRQ_CONTROL: want.irq_control_we = 1'b1;
            IRQ_ACK:     want.irq_ack        = 1'b1;
            default:     ;
          endcase
        end
        default: begin
          if (block inside {[BLK_CHR_FIRST:BLK_CHR_LAST]} && !chr_is_ram) begin
            want.chr_we = 1'b1;
            chg  = CHANGE_CHR;
            slot = chr_idx;
            bank = chr_new;
          end
        end
      endcase
    end
  end

  always_comb begin
    ctl                = want;
    ctl.prg_we         = accept && want.prg_we;
    ctl.chr_we         = accept && want.chr_we;
    ctl.mirror_we      = accept && want.mirror_we;
    ctl.irq_reload_we  = accept && want.irq_reload_we;
    ctl.irq_control_we = accept && want.irq_control_we;
    ctl.irq_ack        = accept && want.irq_ack;
    ctl.tick           = accept && want.tick;
  end

  assign change = chg;

endmodule

// ----- design/bmsi_irq.sv -----
`timescale 1ns / 1ps

module bmsi_irq (
  input  logic           clk,
  input  logic           rst,
  input  bmsi_pkg::ctl_t ctl,
  output logic           fire,
  output logic           clear
);
  import bmsi_pkg::*;

  logic       enabled;
  logic [7:0] reload;
  logic [7:0] count;

  assign fire  = ctl.tick && enabled && (count == 8'd0);
  assign clear = ctl.irq_ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      reload  <= 8'd0;
      count   <= 8'd0;
    end else begin
      if (ctl.irq_reload_we) begin
        reload <= ctl.wdata;
      end
      if (ctl.irq_control_we) begin
        enabled <= ctl.wdata[1];
        if (ctl.wdata[1]) begin
          count <= reload;
        end
      end
      if (ctl.irq_ack) begin
        enabled <= 1'b0;
      end
      if (ctl.tick && enabled) begin
        // expired counter reloads on the same tick that fires
        if (count == 8'd0) begin
          count <= reload;
        end else begin
          count <= count - 8'd1;
        end
      end
    end
  end

endmodule

// ----- design/bank_mapper_with_scanline_irq.sv -----
`timescale 1ns / 1ps

// Cartridge bank mapper with a scanline interrupt counter. Each accepted
// request (a CPU bus write or a scanline tick) yields exactly one result in the
// next cycle, held in an output register until taken; a new request is
// taken every cycle while the output is empty or being taken, so the rate is
// one request per clock, set by the combinational decode ahead of the output
// register. Configuration (chr_is_ram, quad_screen) is written through
// cfg_we/cfg_index/cfg_data and should only change while the block is idle.
module bank_mapper_with_scanline_irq (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic        rendering_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  map_change,
  output logic [2:0]  slot,
  output logic [7:0]  bank,
  output logic [1:0]  mirror_mode,
  output logic        irq_fire,
  output logic        irq_clear,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import bmsi_pkg::*;

  logic       in_accept;
  logic       chr_is_ram;
  logic       quad_screen;
  logic [4:0] prg_bank_regs [2];
  chr_banks_t chr_banks;
  logic [1:0] mirror;
  logic [1:0] mirror_next;
  ctl_t       ctl;
  logic [1:0] dec_change;
  logic [2:0] dec_slot;
  logic [7:0] dec_bank;
  logic       fire;
  logic       clear;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  bmsi_decode u_decode (
    .accept       (in_accept),
    .operation    (operation),
    .address      (address),
    .data         (data),
    .rendering_on (rendering_on),
    .chr_is_ram   (chr_is_ram),
    .quad_screen  (quad_screen),
    .chr_banks    (chr_banks),
    .ctl          (ctl),
    .change       (dec_change),
    .slot         (dec_slot),
    .bank         (dec_bank)
  );

  bmsi_irq u_irq (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .fire  (fire),
    .clear (clear)
  );

  assign mirror_next = ctl.mirror_we ? ctl.wdata[1:0] : mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      chr_is_ram  <= 1'b0;
      quad_screen <= 1'b0;
      prg_bank_regs[0] <= 5'd0;
      prg_bank_regs[1] <= 5'd0;
      chr_banks   <= '0;
      mirror      <= 2'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHR_IS_RAM:  chr_is_ram  <= cfg_data;
          CFG_QUAD_SCREEN: quad_screen <= cfg_data;
          default:         ;
        endcase
      end
      if (ctl.prg_we) begin
        prg_bank_regs[ctl.prg_slot] <= ctl.wdata[4:0];
      end
      if (ctl.chr_we) begin
        chr_banks[ctl.chr_slot] <= ctl.chr_value;
      end
      mirror <= mirror_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (in_accept) begin
      map_change  <= dec_change;
      slot        <= dec_slot;
      bank        <= dec_bank;
      mirror_mode <= mirror_next;
      irq_fire    <= fire;
      irq_clear   <= clear;
    end
  end

  // program bank store is write-only here; the last result carries its value
  logic prg_unused;
  assign prg_unused = ^{prg_bank_regs[0], prg_bank_regs[1]};

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");

  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && map_change == CHANGE_NONE |-> slot == 3'd0 && bank == 8'd0)
    else $error("no-change result carries slot or bank");

  a_fire_no_map: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_fire |-> map_change == CHANGE_NONE && !irq_clear)
    else $error("irq fire combined with a write result");

  a_prg_bank_narrow: assert property (@(posedge clk) disable iff (rst)
    out_valid && map_change == CHANGE_PRG |-> bank[7:5] == 3'd0 && slot[2:1] == 2'd0)
    else $error("program bank result out of range");

  a_prg_store_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(prg_unused))
    else $error("program bank store unknown");

endmodule

// ----- tb/tb_bank_mapper_with_scanline_irq.sv -----
`timescale 1ns / 1ps

module tb_bank_mapper_with_scanline_irq;
  import bmsi_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    change_t    change;
    logic [2:0] slot;
    logic [7:0] bank;
    logic [1:0] mirror;
    logic       fire;
    logic       clr;
  } map_report_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [15:0] address;
  logic [7:0]  data;
  logic        rendering_on;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  map_change;
  logic [2:0]  slot;
  logic [7:0]  bank;
  logic [1:0]  mirror_mode;
  logic        irq_fire;
  logic        irq_clear;
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_data;

  bank_mapper_with_scanline_irq dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .address      (address),
    .data         (data),
    .rendering_on (rendering_on),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .map_change   (map_change),
    .slot         (slot),
    .bank         (bank),
    .mirror_mode  (mirror_mode),
    .irq_fire     (irq_fire),
    .irq_clear    (irq_clear),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mapper state as the cartridge sees it
  logic [4:0] prg_bank [2];
  logic [7:0] chr_bank [8];
  logic [1:0] mirror;
  logic       irq_en;
  logic [7:0] irq_rld;
  logic [7:0] irq_cnt;
  logic       chr_is_ram;
  logic       quad_screen;

  map_report_t map_reports[$];

  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned stall_left;
  int          errors;
  int          cycles;
  int          n_requests;
  int          n_prg;
  int          n_chr;
  int          n_mirror;
  int          n_fire;
  int          n_clear;

  task automatic clear_mapper;
    for (int i = 0; i < 2; i++) prg_bank[i] = '0;
    for (int i = 0; i < 8; i++) chr_bank[i] = '0;
    mirror = '0;
    irq_en = 1'b0;
    irq_rld = '0;
    irq_cnt = '0;
    chr_is_ram = 1'b0;
    quad_screen = 1'b0;
  endtask

  function automatic map_report_t map_request(input logic op, input logic [15:0] addr,
                                              input logic [7:0] wd, input logic rend);
    map_report_t rep;
    logic [3:0]  blk;
    logic [3:0]  chr_off;
    logic [2:0]  ci;
    logic [7:0]  v;
    rep = '0;
    rep.change = CHANGE_NONE;
    blk = addr[15:12];
    if (op == OP_TICK) begin
      if (irq_en && rend) begin
        if (irq_cnt == 8'd0) begin
          irq_cnt = irq_rld;
          rep.fire = 1'b1;
        end else begin
          irq_cnt = irq_cnt - 8'd1;
        end
      end
    end else if (blk == BLK_PRG0) begin
      prg_bank[0] = wd[4:0];
      rep.change = CHANGE_PRG;
      rep.slot = 3'd0;
      rep.bank = {3'b000, wd[4:0]};
    end else if (blk == BLK_PRG1) begin
      if (addr[1]) begin
        mirror = wd[1:0];
        if (!quad_screen) rep.change = CHANGE_MIRROR;
      end else begin
        prg_bank[1] = wd[4:0];
        rep.change = CHANGE_PRG;
        rep.slot = 3'd1;
        rep.bank = {3'b000, wd[4:0]};
      end
    end else if (blk >= BLK_CHR_FIRST && blk <= BLK_CHR_LAST) begin
      if (!chr_is_ram) begin
        chr_off = blk - BLK_CHR_FIRST;
        ci = {chr_off[1:0], addr[2]};
        v = chr_bank[ci];
        // a1 picks which nibble of the bank number is replaced
        if (addr[1]) v[7:4] = wd[3:0];
        else v[3:0] = wd[3:0];
        chr_bank[ci] = v;
        rep.change = CHANGE_CHR;
        rep.slot = ci;
        rep.bank = v;
      end
    end else if (blk == BLK_IRQ) begin
      case (addr[1:0])
        IRQ_RELOAD: irq_rld = wd;
        IRQ_CONTROL: begin
          if (wd[1]) begin
            irq_en = 1'b1;
            irq_cnt = irq_rld;
          end else begin
            irq_en = 1'b0;
          end
        end
        IRQ_ACK: begin
          irq_en = 1'b0;
          rep.clr = 1'b1;
        end
        default: ;
      endcase
    end
    rep.mirror = mirror;
    return rep;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (map_reports.size() == 0) begin
          $display("%0t ns: result with no request pending, map_change %0d", $time, map_change);
          errors++;
        end else begin
          map_report_t want;
          want = map_reports.pop_front();
          check_field("map_change", 8'(want.change), 8'(map_change));
          check_field("slot", 8'(want.slot), 8'(slot));
          check_field("bank", want.bank, bank);
          check_field("mirror_mode", 8'(want.mirror), 8'(mirror_mode));
          check_field("irq_fire", 8'(want.fire), 8'(irq_fire));
          check_field("irq_clear", 8'(want.clr), 8'(irq_clear));
          if (want.change == CHANGE_PRG) n_prg++;
          if (want.change == CHANGE_CHR) n_chr++;
          if (want.change == CHANGE_MIRROR) n_mirror++;
          if (want.fire) n_fire++;
          if (want.clr) n_clear++;
        end
        stall_left = $urandom_range(0, stall_max);
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, map_reports.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [15:0] addr,
                              input logic [7:0] wd, input logic rend);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= addr;
    data <= wd;
    rendering_on <= rend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    map_reports.push_back(map_request(op, addr, wd, rend));
    n_requests++;
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (map_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // only called once the block is drained
  task automatic set_config(input logic ram, input logic four);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHR_IS_RAM;
    cfg_data <= ram;
    @(posedge clk);
    cfg_index <= CFG_QUAD_SCREEN;
    cfg_data <= four;
    @(posedge clk);
    cfg_we <= 1'b0;
    chr_is_ram = ram;
    quad_screen = four;
  endtask

  task automatic test_unused_and_idle;
    gap_max = 0;
    stall_max = 0;
    send_request(OP_TICK, 16'hFFFF, 8'hFF, 1'b1);
    send_request(OP_WRITE, 16'h0000, 8'hFF, 1'b1);
    send_request(OP_WRITE, 16'h7FFF, 8'h00, 1'b0);
    send_request(OP_WRITE, 16'hA5A5, 8'h5A, 1'b1);
    send_request(OP_WRITE, 16'hF003, 8'hFF, 1'b0);
  endtask

  task automatic test_program_banks;
    gap_max = 13;
    stall_max = 13;
    send_request(OP_WRITE, 16'h8000, 8'hFF, 1'b0);
    send_request(OP_WRITE, 16'h9FFD, 8'h00, 1'b1);
    send_request(OP_WRITE, 16'h8FFF, 8'h3F, 1'b0);
  endtask

  task automatic test_mirroring;
    send_request(OP_WRITE, 16'h9002, 8'hFF, 1'b0);
    send_request(OP_WRITE, 16'h9FFE, 8'h01, 1'b1);
  endtask

  task automatic test_character_banks;
    gap_max = 0;
    stall_max = 13;
    send_request(OP_WRITE, 16'hB000, 8'hFF, 1'b0);
    send_request(OP_WRITE, 16'hE006, 8'hA5, 1'b1);
    send_request(OP_WRITE, 16'hC004, 8'h0F, 1'b0);
    send_request(OP_WRITE, 16'hD00A, 8'hF3, 1'b0);
  endtask

  task automatic test_irq_counter;
    gap_max = 13;
    stall_max = 0;
    send_request(OP_WRITE, 16'hF000, 8'h01, 1'b0);
    send_request(OP_WRITE, 16'hF001, 8'h02, 1'b0);
    send_request(OP_TICK, 16'h0000, 8'h00, 1'b0);
    send_request(OP_TICK, 16'hFFFF, 8'hFF, 1'b1);
    send_request(OP_TICK, 16'h1234, 8'h80, 1'b1);
    send_request(OP_WRITE, 16'hF001, 8'hFD, 1'b1);
    send_request(OP_TICK, 16'h0000, 8'h00, 1'b1);
    send_request(OP_WRITE, 16'hF002, 8'h00, 1'b0);
  endtask

  task automatic test_config_extremes;
    wait_drained();
    set_config(1'b1, 1'b1);
    send_request(OP_WRITE, 16'hD002, 8'hFF, 1'b0);
    send_request(OP_WRITE, 16'h9002, 8'h02, 1'b0);
  endtask

  task automatic send_random_request;
    logic        op;
    logic        rend;
    logic [15:0] addr;
    logic [7:0]  wd;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    op = OP_WRITE;
    addr = 16'($urandom);
    wd = 8'($urandom);
    rend = ($urandom_range(0, 7) != 0);
    if (pick < 35) begin
      op = OP_TICK;
    end else if (pick >= 45) begin
      case ($urandom_range(0, 5))
        0: addr[15:12] = BLK_PRG0;
        1: addr[15:12] = BLK_PRG1;
        2, 3: addr[15:12] = 4'($urandom_range(BLK_CHR_FIRST, BLK_CHR_LAST));
        default: begin
          addr[15:12] = BLK_IRQ;
          // short reload values so the counter runs out within a few ticks
          if (addr[1:0] == IRQ_RELOAD && $urandom_range(0, 3) != 0)
            wd = 8'($urandom_range(0, 5));
          if (addr[1:0] == IRQ_ACK && $urandom_range(0, 1) != 0)
            addr[1:0] = IRQ_CONTROL;
        end
      endcase
    end
    send_request(op, addr, wd, rend);
  endtask

  task automatic test_random;
    logic [1:0] settings [5];
    settings = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
    foreach (settings[p]) begin
      wait_drained();
      set_config(settings[p][0], settings[p][1]);
      for (int i = 0; i < 140; i++) begin
        // switch between busy stretches and fully idle-free ones
        if (i % 35 == 0) begin
          gap_max = $urandom_range(0, 1) ? 13 : 0;
          stall_max = $urandom_range(0, 1) ? 13 : 0;
        end
        send_random_request();
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    operation <= OP_WRITE;
    address <= '0;
    data <= '0;
    rendering_on <= 1'b0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_CHR_IS_RAM;
    cfg_data <= 1'b0;
    cycles <= 0;
    errors = 0;
    stall_left = 0;
    gap_max = 0;
    stall_max = 0;
    clear_mapper();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_unused_and_idle();
    test_program_banks();
    test_mirroring();
    test_character_banks();
    test_irq_counter();
    test_config_extremes();
    test_random();

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d requests under four config settings with random idling on both sides",
             n_requests);
    $display("saw %0d program, %0d character, %0d mirroring changes, %0d irq fires, %0d acks",
             n_prg, n_chr, n_mirror, n_fire, n_clear);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
